FILE: rtl/omvf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// omvf_pkg
// Shared types and constants for the online mean and variance unit.
// ----------------------------------------------------------------------------
package omvf_pkg;

  // Width of the fraction-bits register
  localparam int FRAC_W = 5;

  // Sequencer states, one-hot
  typedef enum logic [7:0] {
    ST_IDLE     = 8'b0000_0001,
    ST_DIV_MEAN = 8'b0000_0010,
    ST_MUL_SET  = 8'b0000_0100,
    ST_MUL      = 8'b0000_1000,
    ST_POP_SET  = 8'b0001_0000,
    ST_DIV_POP  = 8'b0010_0000,
    ST_DIV_SMP  = 8'b0100_0000,
    ST_SQRT     = 8'b1000_0000
  } seq_state_t;

endpackage

FILE: rtl/omvf_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// omvf_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module omvf_div #(
  parameter int DVD_W = 32,
  parameter int DIV_W = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DIV_W-1:0] divisor,
  output logic             done,
  output logic [DVD_W-1:0] quotient
);

  localparam int STEP_W = $clog2(DVD_W + 1);

  logic              busy;
  logic [STEP_W-1:0] steps;
  logic [DIV_W-1:0]  rem;
  logic [DIV_W-1:0]  dsr;
  logic [DVD_W-1:0]  dvd;
  logic [DIV_W:0]    rem_sh;
  logic              ge;

  // trial subtraction
  assign rem_sh = {rem, dvd[DVD_W-1]};
  assign ge     = rem_sh >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        steps <= STEP_W'(DVD_W);
      end else if (busy) begin
        steps <= steps - 1'b1;
        if (steps == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath, quotient bits shift into the dividend register
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dsr <= divisor;
      dvd <= dividend;
    end else if (busy) begin
      rem <= ge ? DIV_W'(rem_sh - {1'b0, dsr}) : rem_sh[DIV_W-1:0];
      dvd <= {dvd[DVD_W-2:0], ge};
    end
  end

  assign quotient = dvd;

endmodule

FILE: rtl/omvf_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// omvf_mul
// Shift-and-add unsigned multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module omvf_mul #(
  parameter int OP_W = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [OP_W-1:0]   op_a,
  input  logic [OP_W-1:0]   op_b,
  output logic              done,
  output logic [2*OP_W-1:0] product
);

  localparam int STEP_W = $clog2(OP_W + 1);

  logic              busy;
  logic [STEP_W-1:0] steps;
  logic [2*OP_W-1:0] a_sh;
  logic [OP_W-1:0]   b_sh;
  logic [2*OP_W-1:0] acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        steps <= STEP_W'(OP_W);
      end else if (busy) begin
        steps <= steps - 1'b1;
        if (steps == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // add shifted multiplicand for each set multiplier bit
  always_ff @(posedge clk) begin
    if (start) begin
      a_sh <= (2*OP_W)'(op_a);
      b_sh <= op_b;
      acc  <= '0;
    end else if (busy) begin
      if (b_sh[0]) begin
        acc <= acc + a_sh;
      end
      a_sh <= {a_sh[2*OP_W-2:0], 1'b0};
      b_sh <= {1'b0, b_sh[OP_W-1:1]};
    end
  end

  assign product = acc;

endmodule

FILE: rtl/omvf_sqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// omvf_sqrt
// Bit-serial integer square root, one root bit per cycle.
// ----------------------------------------------------------------------------
module omvf_sqrt #(
  parameter int RAD_W = 62
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [RAD_W-1:0]   radicand,
  output logic               done,
  output logic [RAD_W/2-1:0] root
);

  localparam int N      = RAD_W / 2;
  localparam int STEP_W = $clog2(N + 1);

  logic              busy;
  logic [STEP_W-1:0] steps;
  logic [RAD_W-1:0]  rad;
  logic [N:0]        rem;
  logic [N+2:0]      rem_sh;
  logic [N+2:0]      trial;
  logic              ge;

  assign rem_sh = {rem, rad[RAD_W-1:RAD_W-2]};
  assign trial  = {1'b0, root, 2'b01};
  assign ge     = rem_sh >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        steps <= STEP_W'(N);
      end else if (busy) begin
        steps <= steps - 1'b1;
        if (steps == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // two radicand bits in, one root bit out
  always_ff @(posedge clk) begin
    if (start) begin
      rad  <= radicand;
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      rad  <= {rad[RAD_W-3:0], 2'b00};
      rem  <= ge ? (N+1)'(rem_sh - trial) : rem_sh[N:0];
      root <= {root[N-2:0], ge};
    end
  end

endmodule

FILE: rtl/online_mean_variance_fixed_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// online_mean_variance_fixed_unit
// Welford running mean and variance of signed fixed-point samples.
// ----------------------------------------------------------------------------
//  channel  | signals                        | transfer when
//  ---------+--------------------------------+------------------------------
//  input    | in_valid, in_stall, sample     | in_valid & !in_stall
//  output   | out_valid, out_stall, results  | out_valid & !out_stall
//  config   | cfg_valid, cfg_ready, cfg_data | cfg_valid & cfg_ready
//
// The sequencer runs each sample through the bit-serial divider (mean step,
// two variance divisions), the shift-add multiplier and the square root, and
// takes no new input transfer while a sample is still in flight.
// A first sample skips the mean division, the multiply, the second division
// and the root.
// Reset (rst, synchronous) clears statistics and fraction bits.
// The output register holds a result while out_stall is high; the next
// sample may be taken meanwhile and its result waits to load.
// ----------------------------------------------------------------------------
module online_mean_variance_fixed_unit #(
  parameter int SAMPLE_WIDTH = 32,
  parameter int COUNT_WIDTH  = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [omvf_pkg::FRAC_W-1:0] cfg_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [SAMPLE_WIDTH-1:0]     sample,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [COUNT_WIDTH-1:0]      sample_count,
  output logic [SAMPLE_WIDTH-1:0]     running_mean,
  output logic [SAMPLE_WIDTH-1:0]     pop_variance,
  output logic [SAMPLE_WIDTH-1:0]     smp_variance,
  output logic [SAMPLE_WIDTH-2:0]     std_deviation
);

  import omvf_pkg::*;

  localparam int W     = SAMPLE_WIDTH;
  localparam int C     = COUNT_WIDTH;
  localparam int RAD_W = 2 * ((W + 31) / 2);
  localparam int RT_W  = RAD_W / 2;
  localparam int RX_W  = (RT_W > W - 1) ? RT_W : W - 1;
  localparam int PX_W  = 2 * W + 32;

  seq_state_t      state;
  logic [FRAC_W-1:0] frac;
  logic [C-1:0]    cnt;
  logic [C-1:0]    cnt_next;
  logic [W-1:0]    mean;
  logic [W-1:0]    m2;
  logic [W-1:0]    smp;
  logic [W-1:0]    d1;
  logic            prod_neg;
  logic            div_neg;
  logic [W-1:0]    pvar;
  logic [W-1:0]    svar;
  logic            in_take;

  logic            div_start, div_done;
  logic            mul_start, mul_done;
  logic            sqrt_start, sqrt_done;
  logic [W-1:0]    div_dvd;
  logic [C-1:0]    div_dsr;
  logic [W-1:0]    div_q;
  logic [W-1:0]    div_sq;
  logic [W-1:0]    mul_a, mul_b;
  logic [2*W-1:0]  mul_p;
  logic [RAD_W-1:0] sqrt_rad;
  logic [RT_W-1:0] sqrt_root;
  logic [RX_W-1:0] root_ext;
  logic [W-1:0]    d1_new;
  logic [W-1:0]    d2;
  logic [2*W:0]    prod_s;
  logic [PX_W-1:0] prod_x;
  logic [W-1:0]    m2_new;
  logic            cnt_ge2;
  logic            load_out;
  logic [W-1:0]    sd_val;
  logic            sd_load;

  // arithmetic units; the divider is shared by the three divisions
  omvf_div #(.DVD_W(W), .DIV_W(C)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(div_dvd),
    .divisor(div_dsr), .done(div_done), .quotient(div_q)
  );

  omvf_mul #(.OP_W(W)) u_mul (
    .clk(clk), .rst(rst), .start(mul_start), .op_a(mul_a), .op_b(mul_b),
    .done(mul_done), .product(mul_p)
  );

  omvf_sqrt #(.RAD_W(RAD_W)) u_sqrt (
    .clk(clk), .rst(rst), .start(sqrt_start), .radicand(sqrt_rad),
    .done(sqrt_done), .root(sqrt_root)
  );

  // combinational helpers
  assign cnt_next = (cnt == {C{1'b1}}) ? cnt : cnt + 1'b1;
  assign cnt_ge2  = cnt[C-1:1] != '0;
  assign d1_new   = sample - mean;
  assign d2       = smp - mean;
  assign div_sq   = div_neg ? W'(-div_q) : div_q;
  assign prod_s   = prod_neg ? (2*W+1)'(-{1'b0, mul_p}) : {1'b0, mul_p};
  assign prod_x   = PX_W'($signed(prod_s)) >>> frac;
  assign m2_new   = m2 + prod_x[W-1:0];
  assign root_ext = RX_W'(sqrt_root);
  // radicand taken straight from the quotient as the root starts
  assign sqrt_rad = RAD_W'(div_sq) << frac;
  assign mul_a    = d1[W-1] ? W'(-d1) : d1;
  assign mul_b    = d2[W-1] ? W'(-d2) : d2;

  // idle and no result waiting; a register write takes priority
  assign cfg_ready = (state == ST_IDLE) && !sd_load;
  assign in_stall  = (state != ST_IDLE) || sd_load || cfg_valid;
  assign in_take   = in_valid && !in_stall;

  // result lands when the sequencer finishes and the output register is free
  assign load_out = sd_load && (!out_valid || !out_stall);

  // unit start strobes and operands
  always_comb begin
    div_start  = 1'b0;
    mul_start  = 1'b0;
    sqrt_start = 1'b0;
    div_dvd    = m2[W-1] ? W'(-m2) : m2;
    div_dsr    = cnt;
    unique case (state)
      ST_IDLE: begin
        if (in_take && cnt_next != C'(1)) begin
          div_start = 1'b1;
          div_dvd   = d1_new[W-1] ? W'(-d1_new) : d1_new;
          div_dsr   = cnt_next;
        end
      end
      ST_MUL_SET: mul_start = 1'b1;
      ST_POP_SET: div_start = 1'b1;
      ST_DIV_POP: begin
        if (div_done && cnt_ge2) begin
          div_start = 1'b1;
          div_dsr   = cnt - 1'b1;
        end
      end
      ST_DIV_SMP: sqrt_start = div_done && !div_sq[W-1];
      default: ;
    endcase
  end

  // sequencer and statistics
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      frac    <= '0;
      cnt     <= '0;
      mean    <= '0;
      m2      <= '0;
      sd_load <= 1'b0;
    end else begin
      if (load_out) begin
        sd_load <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (cfg_valid && cfg_ready) begin
            frac <= cfg_data;
            cnt  <= '0;
            mean <= '0;
            m2   <= '0;
          end else if (in_take) begin
            cnt <= cnt_next;
            smp <= sample;
            if (cnt_next == C'(1)) begin
              mean  <= sample;
              m2    <= '0;
              state <= ST_POP_SET;
            end else begin
              d1      <= d1_new;
              div_neg <= d1_new[W-1];
              state   <= ST_DIV_MEAN;
            end
          end
        end
        ST_DIV_MEAN: begin
          if (div_done) begin
            mean  <= mean + div_sq;
            state <= ST_MUL_SET;
          end
        end
        ST_MUL_SET: begin
          prod_neg <= d1[W-1] ^ d2[W-1];
          state    <= ST_MUL;
        end
        ST_MUL: begin
          if (mul_done) begin
            m2    <= m2_new;
            state <= ST_POP_SET;
          end
        end
        ST_POP_SET: begin
          div_neg <= m2[W-1];
          state   <= ST_DIV_POP;
        end
        ST_DIV_POP: begin
          if (div_done) begin
            pvar <= div_sq;
            if (cnt_ge2) begin
              state <= ST_DIV_SMP;
            end else begin
              svar    <= '0;
              sd_val  <= '0;
              sd_load <= 1'b1;
              state   <= ST_IDLE;
            end
          end
        end
        ST_DIV_SMP: begin
          if (div_done) begin
            svar <= div_sq;
            if (div_sq[W-1]) begin
              sd_val  <= '0;
              sd_load <= 1'b1;
              state   <= ST_IDLE;
            end else begin
              state <= ST_SQRT;
            end
          end
        end
        ST_SQRT: begin
          if (sqrt_done) begin
            sd_val  <= W'(root_ext[W-2:0]);
            sd_load <= 1'b1;
            state   <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      sample_count  <= cnt;
      running_mean  <= mean;
      pop_variance  <= pvar;
      smp_variance  <= svar;
      std_deviation <= sd_val[W-2:0];
    end
  end

endmodule
